@@ hdl/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ hdl/nla_pkg.sv @@
// Shared constants, types and state codes of the nearest landmark association block.
package nla_pkg;

	localparam int MAX_LANDMARKS = 256;
	localparam int MAX_FEATURES = 256;

	localparam int SCAN_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
	localparam int CNT_W = $clog2(MAX_LANDMARKS + 1);
	localparam int FEAT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

	localparam int COORD_W = 24;
	localparam int DIFF_W = 25;
	localparam int SQ_W = 48;
	localparam int DIST_W = 50;
	localparam int RADIUS_W = 52;
	localparam int LIDX_W = 9;
	localparam int FIDX_W = 8;
	localparam int OUTC_W = 2;
	localparam int CMD_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int HITS_W = 2;

	// Latency of the distance pipeline and width of its drain counter
	localparam int DIST_LAT = 3;
	localparam int DRAIN_W = 2;

	localparam logic [DIST_W-1:0] INIT_MIN_DIST = 50'd655360000000000;
	localparam logic [LIDX_W-1:0] NO_LANDMARK = 9'd511;
	localparam logic [RADIUS_W-1:0] MATCH_RADIUS_RST = 52'd65536;
	localparam logic [RADIUS_W-1:0] NEW_RADIUS_RST = 52'd41943;
	localparam logic [HITS_W-1:0] HITS_MANY = 2'd2;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ASSOC = 2'd2;

	// Outcome codes
	localparam logic [OUTC_W-1:0] OUTC_MATCH = 2'd0;
	localparam logic [OUTC_W-1:0] OUTC_NEW = 2'd1;
	localparam logic [OUTC_W-1:0] OUTC_AMBIG = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_RADIUS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEW_RADIUS = 1'd1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef struct packed {
		logic valid;
		logic [SCAN_W-1:0] idx;
	} dist_tag_t;

	typedef struct packed {
		logic valid;
		logic [SCAN_W-1:0] idx;
		logic [DIST_W-1:0] dsq;
	} dist_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

@@ hdl/nla_cell.sv @@
// One landmark cell of the rotating store ring.
module nla_cell (
	input  logic            clk,
	input  logic            load_en,
	input  nla_pkg::point_t load_data,
	input  logic            shift_en,
	input  nla_pkg::point_t shift_in,
	output nla_pkg::point_t data
);

	nla_pkg::point_t data_q;

	// Capture a loaded landmark, otherwise take the neighbor's entry while rotating
	always_ff @(posedge clk) begin
		if (load_en) begin
			data_q <= load_data;
		end else if (shift_en) begin
			data_q <= shift_in;
		end
	end

	assign data = data_q;

endmodule

@@ hdl/nla_dist.sv @@
// Three-stage squared distance pipeline between a query and one landmark.
module nla_dist (
	input  logic               clk,
	input  logic               arst_n,
	input  nla_pkg::dist_tag_t tag,
	input  nla_pkg::point_t    query,
	input  nla_pkg::point_t    landmark,
	output nla_pkg::dist_res_t res
);

	logic                              valid_s1, valid_s2, valid_s3;
	logic [nla_pkg::SCAN_W-1:0]        idx_s1, idx_s2, idx_s3;
	logic signed [nla_pkg::DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [nla_pkg::SQ_W-1:0]          sqx_s2, sqy_s2, sqz_s2;
	logic [nla_pkg::DIST_W-1:0]        dist_s3;
	logic signed [2*nla_pkg::DIFF_W-1:0] prod_x, prod_y, prod_z;

	// Advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= tag.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: coordinate differences
	always_ff @(posedge clk) begin
		idx_s1 <= tag.idx;
		dx_s1  <= nla_pkg::DIFF_W'(query.x) - nla_pkg::DIFF_W'(landmark.x);
		dy_s1  <= nla_pkg::DIFF_W'(query.y) - nla_pkg::DIFF_W'(landmark.y);
		dz_s1  <= nla_pkg::DIFF_W'(query.z) - nla_pkg::DIFF_W'(landmark.z);
	end

	// Stage 2: squares, each below 2^48
	assign prod_x = dx_s1 * dx_s1;
	assign prod_y = dy_s1 * dy_s1;
	assign prod_z = dz_s1 * dz_s1;

	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
		sqx_s2 <= prod_x[nla_pkg::SQ_W-1:0];
		sqy_s2 <= prod_y[nla_pkg::SQ_W-1:0];
		sqz_s2 <= prod_z[nla_pkg::SQ_W-1:0];
	end

	// Stage 3: sum of squares
	always_ff @(posedge clk) begin
		idx_s3  <= idx_s2;
		dist_s3 <= nla_pkg::DIST_W'(sqx_s2) + nla_pkg::DIST_W'(sqy_s2)
			+ nla_pkg::DIST_W'(sqz_s2);
	end

	assign res.valid = valid_s3;
	assign res.idx   = idx_s3;
	assign res.dsq   = dist_s3;

endmodule

@@ hdl/nearest_landmark_association.sv @@
// Top level of the nearest landmark association block.
//
// Requests enter on start/command/pos_x/pos_y/pos_z and are taken at a rising edge with
// start high and busy low. Start-frame clears the landmark, feature and new-landmark
// counters; load appends a landmark to the store (ignored when full). Both cause no
// result and never raise busy, so they may follow each other every cycle.
// An associate request rotates the ring of MAX_LANDMARKS landmark cells once past a single
// three-stage distance pipeline: busy stays high through the ring rotation, the pipeline
// drain and the decision state.
// The result is shown on feature_index, landmark_index, outcome and min_distance_sq for
// one cycle with done high; the next request may be taken in that same cycle.
// The receiver cannot stall, so results are never held.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 is the match radius, index 1 the new-landmark radius, both squared.
// Reset clears all counters and loads the default radii; store contents are undefined
// until loaded and need no clearing pass.
module nearest_landmark_association (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [nla_pkg::CMD_W-1:0]          command,
	input  logic signed [nla_pkg::COORD_W-1:0] pos_x,
	input  logic signed [nla_pkg::COORD_W-1:0] pos_y,
	input  logic signed [nla_pkg::COORD_W-1:0] pos_z,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [nla_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nla_pkg::RADIUS_W-1:0]       cfg_data,
	output logic                               done,
	output logic [nla_pkg::FIDX_W-1:0]         feature_index,
	output logic [nla_pkg::LIDX_W-1:0]         landmark_index,
	output logic [nla_pkg::OUTC_W-1:0]         outcome,
	output logic [nla_pkg::RADIUS_W-1:0]       min_distance_sq
);

	nla_pkg::state_t state_q, state_d;

	logic [nla_pkg::RADIUS_W-1:0] match_radius_q, new_radius_q;
	logic [nla_pkg::CNT_W-1:0]    lm_count_q;
	logic [nla_pkg::FEAT_W-1:0]   feat_count_q;
	logic [nla_pkg::LIDX_W-1:0]   newlm_count_q;
	logic [nla_pkg::SCAN_W-1:0]   scan_cnt_q;
	logic [nla_pkg::DRAIN_W-1:0]  drain_q;
	logic [nla_pkg::HITS_W-1:0]   hits_q;
	logic [nla_pkg::DIST_W-1:0]   dmin_q;
	logic [nla_pkg::LIDX_W-1:0]   best_q;
	nla_pkg::point_t              pos_q;
	nla_pkg::point_t              req_pt;

	logic                         done_q;
	logic [nla_pkg::FIDX_W-1:0]   fidx_q;
	logic [nla_pkg::LIDX_W-1:0]   lidx_q;
	logic [nla_pkg::OUTC_W-1:0]   outc_q;
	logic [nla_pkg::RADIUS_W-1:0] dist_out_q;

	logic accept, do_start, do_load, do_assoc;
	logic scan_last, ring_shift, finish;
	logic [nla_pkg::MAX_LANDMARKS-1:0] load_hit;
	nla_pkg::point_t    cell_data [nla_pkg::MAX_LANDMARKS];
	nla_pkg::dist_tag_t dist_tag;
	nla_pkg::dist_res_t dist_res;
	logic [nla_pkg::OUTC_W-1:0] outc_d;
	logic [nla_pkg::LIDX_W-1:0] lidx_d;

	// Decode the accepted request
	assign accept   = start && !busy;
	assign do_start = accept && (command == nla_pkg::CMD_START);
	assign do_load  = accept && (command == nla_pkg::CMD_LOAD)
		&& (lm_count_q < nla_pkg::CNT_W'(nla_pkg::MAX_LANDMARKS));
	assign do_assoc = accept && (command == nla_pkg::CMD_ASSOC);
	assign req_pt   = '{x: pos_x, y: pos_y, z: pos_z};

	assign scan_last = (scan_cnt_q == nla_pkg::SCAN_W'(nla_pkg::MAX_LANDMARKS - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nla_pkg::ST_IDLE: begin
				if (do_assoc) begin
					state_d = nla_pkg::ST_SCAN;
				end
			end
			nla_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = nla_pkg::ST_DRAIN;
				end
			end
			nla_pkg::ST_DRAIN: begin
				if (drain_q == '0) begin
					state_d = nla_pkg::ST_FINISH;
				end
			end
			nla_pkg::ST_FINISH: begin
				state_d = nla_pkg::ST_IDLE;
			end
			default: begin
				state_d = nla_pkg::ST_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		busy       = 1'b1;
		ring_shift = 1'b0;
		finish     = 1'b0;
		unique case (state_q)
			nla_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			nla_pkg::ST_SCAN: begin
				ring_shift = 1'b1;
			end
			nla_pkg::ST_DRAIN: begin
				busy = 1'b1;
			end
			nla_pkg::ST_FINISH: begin
				finish = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Landmark ring: entry l sits in cell l at rest and rotates once per query
	generate
		for (genvar i = 0; i < nla_pkg::MAX_LANDMARKS; i++) begin : g_cell
			assign load_hit[i] = do_load && (lm_count_q == nla_pkg::CNT_W'(i));
			nla_cell u_cell (
				.clk       (clk),
				.load_en   (load_hit[i]),
				.load_data (req_pt),
				.shift_en  (ring_shift),
				.shift_in  (cell_data[(i + 1) % nla_pkg::MAX_LANDMARKS]),
				.data      (cell_data[i])
			);
		end
	endgenerate

	// Issue the landmark at the head of the ring while it is a stored one
	assign dist_tag.valid = ring_shift
		&& (nla_pkg::CNT_W'(scan_cnt_q) < lm_count_q);
	assign dist_tag.idx   = scan_cnt_q;

	nla_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag      (dist_tag),
		.query    (pos_q),
		.landmark (cell_data[0]),
		.res      (dist_res)
	);

	// Decide the outcome from the final minimum and hit count
	always_comb begin
		if ((hits_q == '0) && (nla_pkg::RADIUS_W'(dmin_q) > new_radius_q)) begin
			outc_d = nla_pkg::OUTC_NEW;
			lidx_d = nla_pkg::LIDX_W'(lm_count_q) + newlm_count_q;
		end else if (hits_q == nla_pkg::HITS_MANY) begin
			outc_d = nla_pkg::OUTC_AMBIG;
			lidx_d = best_q;
		end else begin
			outc_d = nla_pkg::OUTC_MATCH;
			lidx_d = best_q;
		end
	end

	// Control registers: state, counters, radii
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= nla_pkg::ST_IDLE;
			match_radius_q <= nla_pkg::MATCH_RADIUS_RST;
			new_radius_q   <= nla_pkg::NEW_RADIUS_RST;
			lm_count_q     <= '0;
			feat_count_q   <= '0;
			newlm_count_q  <= '0;
			scan_cnt_q     <= '0;
			drain_q        <= '0;
			hits_q         <= '0;
			done_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;

			// Take configuration writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					nla_pkg::REG_MATCH_RADIUS: match_radius_q <= cfg_data;
					nla_pkg::REG_NEW_RADIUS:   new_radius_q   <= cfg_data;
					default: ;
				endcase
			end

			if (do_start) begin
				lm_count_q    <= '0;
				feat_count_q  <= '0;
				newlm_count_q <= '0;
			end
			if (do_load) begin
				lm_count_q <= lm_count_q + 1'b1;
			end

			// Advance scan and drain counters
			if (do_assoc) begin
				scan_cnt_q <= '0;
				hits_q     <= '0;
			end else if (ring_shift) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (ring_shift && scan_last) begin
				drain_q <= nla_pkg::DRAIN_W'(nla_pkg::DIST_LAT - 1);
			end else if (state_q == nla_pkg::ST_DRAIN) begin
				drain_q <= drain_q - 1'b1;
			end

			// Count improving steps inside the match radius, saturating at many
			if (dist_res.valid && (dist_res.dsq < dmin_q)
				&& (nla_pkg::RADIUS_W'(dist_res.dsq) < match_radius_q)
				&& (hits_q != nla_pkg::HITS_MANY)) begin
				hits_q <= hits_q + 1'b1;
			end

			if (finish) begin
				if (feat_count_q < nla_pkg::FEAT_W'(nla_pkg::MAX_FEATURES - 1)) begin
					feat_count_q <= feat_count_q + 1'b1;
				end
				if (outc_d == nla_pkg::OUTC_NEW) begin
					newlm_count_q <= newlm_count_q + 1'b1;
				end
			end
		end
	end

	// Payload registers: query, running minimum, result
	always_ff @(posedge clk) begin
		if (do_assoc) begin
			pos_q  <= req_pt;
			dmin_q <= nla_pkg::INIT_MIN_DIST;
			best_q <= nla_pkg::NO_LANDMARK;
		end else if (dist_res.valid && (dist_res.dsq < dmin_q)) begin
			dmin_q <= dist_res.dsq;
			best_q <= nla_pkg::LIDX_W'(dist_res.idx);
		end
		if (finish) begin
			fidx_q     <= nla_pkg::FIDX_W'(feat_count_q);
			lidx_q     <= lidx_d;
			outc_q     <= outc_d;
			dist_out_q <= nla_pkg::RADIUS_W'(dmin_q);
		end
	end

	assign cfg_ready       = 1'b1;
	assign done            = done_q;
	assign feature_index   = fidx_q;
	assign landmark_index  = lidx_q;
	assign outcome         = outc_q;
	assign min_distance_sq = dist_out_q;

endmodule

@@ hdl/nla_checker.sv @@
// Port-level checker of the nearest landmark association block and its bind.
`include "assert_macros.svh"

module nla_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic [nla_pkg::CMD_W-1:0]          command,
	input logic                               done,
	input logic [nla_pkg::OUTC_W-1:0]         outcome,
	input logic [nla_pkg::RADIUS_W-1:0]       min_distance_sq
);

	// A result only appears once the scan has ended
	`ASSERT_CLK(a_done_idle, done |-> !busy, "result strobe while busy")

	// Results are single-cycle and queries are far apart
	`ASSERT_CLK(a_done_single, done |=> !done, "result strobe held two cycles")

	// An accepted associate request occupies the block
	`ASSERT_CLK(a_assoc_busy, (start && !busy && (command == nla_pkg::CMD_ASSOC)) |=> busy,
		"associate request did not raise busy")

	// Outcome is one of the three defined codes
	`ASSERT_NEVER(a_outcome_code, done && (outcome != nla_pkg::OUTC_MATCH)
		&& (outcome != nla_pkg::OUTC_NEW) && (outcome != nla_pkg::OUTC_AMBIG),
		"undefined outcome code")

	// The reported minimum never exceeds the initial search bound
	`ASSERT_NEVER(a_dist_bound,
		done && (min_distance_sq > nla_pkg::RADIUS_W'(nla_pkg::INIT_MIN_DIST)),
		"minimum distance above initial bound")

endmodule

bind nearest_landmark_association nla_checker u_nla_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.command         (command),
	.done            (done),
	.outcome         (outcome),
	.min_distance_sq (min_distance_sq)
);

@@ verif/tb.sv @@
// Self-checking testbench for the nearest landmark association block.
module tb;
	import nla_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned SETTLE_CYCLES = MAX_LANDMARKS + 8;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned PHASE_ITEMS = 16;
	localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

	typedef struct packed {
		bit [FIDX_W-1:0] feat;
		bit [LIDX_W-1:0] lm;
		bit [OUTC_W-1:0] outc;
		bit [RADIUS_W-1:0] dsq;
	} assoc_result_t;

	// Association predictor and result checker
	class assoc_scoreboard;
		point_t landmarks[MAX_LANDMARKS];
		int unsigned landmark_count;
		int unsigned feature_count;
		int unsigned new_count;
		bit [RADIUS_W-1:0] match_radius;
		bit [RADIUS_W-1:0] new_radius;
		assoc_result_t pending_results[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned loads;
		int unsigned peak_landmarks;
		int unsigned outcome_seen[3];
		bit feature_saturated;

		function new();
			landmark_count = 0;
			feature_count = 0;
			new_count = 0;
			match_radius = MATCH_RADIUS_RST;
			new_radius = NEW_RADIUS_RST;
			mismatches = 0;
			checked = 0;
			loads = 0;
			peak_landmarks = 0;
			feature_saturated = 0;
			outcome_seen = '{0, 0, 0};
		endfunction

		function void set_register(bit [CFG_IDX_W-1:0] idx, bit [RADIUS_W-1:0] data);
			if (idx == REG_MATCH_RADIUS) begin
				match_radius = data;
			end else if (idx == REG_NEW_RADIUS) begin
				new_radius = data;
			end
		endfunction

		function bit [DIST_W-1:0] distance_sq(point_t a, point_t b);
			longint dx;
			longint dy;
			longint dz;
			dx = longint'($signed(a.x)) - longint'($signed(b.x));
			dy = longint'($signed(a.y)) - longint'($signed(b.y));
			dz = longint'($signed(a.z)) - longint'($signed(b.z));
			return DIST_W'(dx * dx + dy * dy + dz * dz);
		endfunction

		// Scan the store in order and classify the feature
		function assoc_result_t associate(point_t p);
			bit [DIST_W-1:0] d;
			bit [DIST_W-1:0] dmin;
			bit [LIDX_W-1:0] best;
			int unsigned hits;
			assoc_result_t r;
			dmin = INIT_MIN_DIST;
			best = NO_LANDMARK;
			hits = 0;
			for (int unsigned l = 0; l < landmark_count; l++) begin
				d = distance_sq(p, landmarks[l]);
				if (d < dmin) begin
					dmin = d;
					best = LIDX_W'(l);
					if (RADIUS_W'(d) < match_radius) hits++;
				end
			end
			if (hits == 0 && RADIUS_W'(dmin) > new_radius) begin
				r.outc = OUTC_NEW;
				r.lm = LIDX_W'(landmark_count + new_count);
				new_count = (new_count + 1) & 32'h1FF;
			end else if (hits > 1) begin
				r.outc = OUTC_AMBIG;
				r.lm = best;
			end else begin
				r.outc = OUTC_MATCH;
				r.lm = best;
			end
			r.feat = FIDX_W'(feature_count);
			r.dsq = RADIUS_W'(dmin);
			if (feature_count < MAX_FEATURES - 1) begin
				feature_count++;
			end else begin
				feature_saturated = 1;
			end
			return r;
		endfunction

		function void note_request(logic [CMD_W-1:0] cmd, point_t p);
			case (cmd)
				CMD_START: begin
					landmark_count = 0;
					feature_count = 0;
					new_count = 0;
				end
				CMD_LOAD: begin
					loads++;
					if (landmark_count < MAX_LANDMARKS) begin
						landmarks[landmark_count] = p;
						landmark_count++;
						if (landmark_count > peak_landmarks) peak_landmarks = landmark_count;
					end
				end
				CMD_ASSOC: pending_results.insert(pending_results.size(), associate(p));
				default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			if (mismatches < 40) $display("mismatch: %s", what);
			mismatches++;
		endtask

		task check_result(logic [FIDX_W-1:0] fi, logic [LIDX_W-1:0] li,
				logic [OUTC_W-1:0] oc, logic [RADIUS_W-1:0] ds);
			assoc_result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing outstanding, feature %0d", fi));
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (want.outc <= OUTC_AMBIG) outcome_seen[want.outc]++;
			if (fi !== want.feat)
				report_mismatch($sformatf("feature_index %0d, want %0d", fi, want.feat));
			if (li !== want.lm)
				report_mismatch($sformatf("feature %0d landmark_index %0d, want %0d",
					want.feat, li, want.lm));
			if (oc !== want.outc)
				report_mismatch($sformatf("feature %0d outcome %0d, want %0d",
					want.feat, oc, want.outc));
			if (ds !== want.dsq)
				report_mismatch($sformatf("feature %0d min_distance_sq %0d, want %0d",
					want.feat, ds, want.dsq));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [CMD_W-1:0] command = CMD_START;
	logic signed [COORD_W-1:0] pos_x = '0;
	logic signed [COORD_W-1:0] pos_y = '0;
	logic signed [COORD_W-1:0] pos_z = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MATCH_RADIUS;
	logic [RADIUS_W-1:0] cfg_data = '0;
	logic done;
	logic [FIDX_W-1:0] feature_index;
	logic [LIDX_W-1:0] landmark_index;
	logic [OUTC_W-1:0] outcome;
	logic [RADIUS_W-1:0] min_distance_sq;

	assoc_scoreboard sb = new();
	int unsigned idle_pct = 0;
	int unsigned item_count = 0;
	int unsigned cycle_count = 0;

	nearest_landmark_association dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.feature_index(feature_index),
		.landmark_index(landmark_index),
		.outcome(outcome),
		.min_distance_sq(min_distance_sq)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check every result on the cycle its strobe is high
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(feature_index, landmark_index, outcome, min_distance_sq);
	end

	// Guard against a hung block
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending_results.size());
			$display("FAIL nearest_landmark_association");
			$finish;
		end
	end

	function automatic point_t pt(int x, int y, int z);
		point_t p;
		p.x = x[COORD_W-1:0];
		p.y = y[COORD_W-1:0];
		p.z = z[COORD_W-1:0];
		return p;
	endfunction

	function automatic point_t random_point();
		return pt($urandom(), $urandom(), $urandom());
	endfunction

	// Jitter each coordinate by up to +/- spread, wrapping at 24 bits
	function automatic point_t near(point_t c, int unsigned spread);
		point_t p;
		int off;
		off = $urandom_range(2 * spread) - spread;
		p.x = c.x + off[COORD_W-1:0];
		off = $urandom_range(2 * spread) - spread;
		p.y = c.y + off[COORD_W-1:0];
		off = $urandom_range(2 * spread) - spread;
		p.z = c.z + off[COORD_W-1:0];
		return p;
	endfunction

	// Drive one request, with an optional idle gap first, and wait for it to be taken
	task automatic issue(logic [CMD_W-1:0] cmd, point_t p);
		point_t junk;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			junk = random_point();
			start <= 1'b0;
			command <= CMD_W'($urandom_range(3));
			pos_x <= junk.x;
			pos_y <= junk.y;
			pos_z <= junk.z;
			@(posedge clk);
			if ($urandom_range(3) == 0) begin
				while (busy) @(posedge clk);
			end
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		pos_x <= p.x;
		pos_y <= p.y;
		pos_z <= p.z;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(cmd, p);
		if (cmd != CMD_UNUSED) item_count++;
	endtask

	// Hold off requests until every result is in and the block has gone quiet
	task automatic settle();
		start <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RADIUS_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(idx, data);
	endtask

	task automatic program_radii(logic [RADIUS_W-1:0] match_r, logic [RADIUS_W-1:0] new_r);
		write_reg(REG_MATCH_RADIUS, match_r);
		write_reg(REG_NEW_RADIUS, new_r);
		cfg_valid <= 1'b0;
	endtask

	// One frame: optional start, a cluster of landmarks, then feature queries with noise
	task automatic run_frame(int unsigned n_loads, int unsigned n_assoc, int unsigned spread,
			bit force_start);
		point_t centre;
		point_t p;
		point_t placed[$];
		int unsigned sel;
		centre = random_point();
		if (force_start || $urandom_range(4) != 0) issue(CMD_START, random_point());
		repeat (n_loads) begin
			p = near(centre, spread);
			placed.insert(placed.size(), p);
			issue(CMD_LOAD, p);
			if ($urandom_range(19) == 0) issue(CMD_UNUSED, random_point());
			if ($urandom_range(24) == 0) issue(CMD_LOAD, random_point());
		end
		repeat (n_assoc) begin
			sel = $urandom_range(9);
			if (sel < 2 || placed.size() == 0) begin
				p = (sel < 2) ? random_point() : near(centre, spread);
			end else if (sel < 4) begin
				p = placed[$urandom_range(placed.size() - 1)];
			end else if (sel < 7) begin
				p = near(placed[$urandom_range(placed.size() - 1)], 200);
			end else begin
				p = near(centre, spread);
			end
			issue(CMD_ASSOC, p);
			if ($urandom_range(19) == 0) issue(CMD_UNUSED, random_point());
			if ($urandom_range(39) == 0) issue(CMD_START, random_point());
		end
	endtask

	initial begin
		int unsigned phase_start;
		int unsigned spread;
		logic [RADIUS_W-1:0] r_match;
		logic [RADIUS_W-1:0] r_new;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: default radii, no gaps
		issue(CMD_ASSOC, pt(5, 5, 5));            // query with an empty store
		issue(CMD_UNUSED, random_point());
		issue(CMD_LOAD, pt(0, 0, 0));
		issue(CMD_LOAD, pt(200, 0, 0));
		issue(CMD_LOAD, pt(100, 0, 0));
		issue(CMD_ASSOC, pt(300, 0, 0));          // single hit, later landmark not improving
		issue(CMD_ASSOC, pt(0, 0, 0));            // exact hit, zero distance
		issue(CMD_ASSOC, pt(250, 0, 0));          // two improving hits: ambiguous
		issue(CMD_ASSOC, pt(1000, 0, 0));         // far from all: new landmark
		issue(CMD_ASSOC, pt(-180, 0, 0));
		issue(CMD_START, random_point());
		issue(CMD_LOAD, pt(10, 0, 0));
		issue(CMD_LOAD, pt(-10, 0, 0));
		issue(CMD_ASSOC, pt(0, 0, 0));            // equal distances keep the first
		issue(CMD_START, random_point());
		issue(CMD_LOAD, pt(C_MAX, C_MAX, C_MAX));
		issue(CMD_ASSOC, pt(C_MIN, C_MIN, C_MIN)); // beyond the initial minimum
		issue(CMD_ASSOC, pt(C_MAX, C_MIN, 0));
		issue(CMD_START, random_point());

		// Directed: no match radius, new radius at maximum
		settle();
		program_radii('0, '1);
		issue(CMD_LOAD, pt(C_MAX, C_MAX, C_MAX));
		issue(CMD_ASSOC, pt(C_MIN, C_MIN, C_MIN)); // nothing in range reports no landmark
		issue(CMD_ASSOC, pt(C_MAX, C_MAX, C_MAX));
		issue(CMD_ASSOC, pt(C_MAX - 3, C_MAX, C_MIN));

		// Random phases, each with its own radii; phases 1 and 3 add idle gaps
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
				0: begin
					r_match = MATCH_RADIUS_RST;
					r_new = NEW_RADIUS_RST;
				end
				1: begin
					r_match = '1;
					r_new = '0;
				end
				2: begin
					r_match = RADIUS_W'({$urandom(), $urandom()}) >> $urandom_range(40);
					r_new = RADIUS_W'({$urandom(), $urandom()}) >> $urandom_range(40);
				end
				default: begin
					r_match = 52'd1048576;
					r_new = 52'd262144;
				end
			endcase
			program_radii(r_match, r_new);
			idle_pct = (ph == 1) ? 48 : (ph == 3) ? 28 : 0;
			phase_start = item_count;
			while (item_count - phase_start < PHASE_ITEMS) begin
				case ($urandom_range(3))
					0: spread = 32;
					1: spread = 256;
					2: spread = 1024;
					default: spread = 8192;
				endcase
				run_frame($urandom_range(8), $urandom_range(1, 6), spread, 1'b0);
			end
			// Overfill the store and run the feature index into saturation
			if (ph == 3) begin
				run_frame(MAX_LANDMARKS + $urandom_range(1, 4), MAX_FEATURES + $urandom_range(2, 4),
					2048, 1'b1);
			end
		end

		settle();
		$display("covered %0d requests (%0d loads, store peak %0d, feature index saturated %0d)",
			item_count, sb.loads, sb.peak_landmarks, sb.feature_saturated);
		$display("checked %0d results: %0d matched, %0d new, %0d ambiguous; %0d mismatches",
			sb.checked, sb.outcome_seen[0], sb.outcome_seen[1], sb.outcome_seen[2], sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("PASS nearest_landmark_association");
		end else begin
			$display("FAIL nearest_landmark_association");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/nla_pkg.sv
hdl/nla_cell.sv
hdl/nla_dist.sv
hdl/nearest_landmark_association.sv
hdl/nla_checker.sv
verif/tb.sv
